FILE: hdl/ercx_pkg.sv
`timescale 1ns / 1ps

package ercx_pkg;

    // Data memory depth in words; must be a power of two (256 to 65536).
    localparam int MEM_DEPTH = 65536;
    localparam int MEM_AW    = $clog2(MEM_DEPTH);

    localparam int NUM_REGS  = 8;
    localparam int REG_AW    = 3;
    localparam int DATA_W    = 32;
    localparam int PC_W      = 16;

    typedef enum logic [2:0] {
        CMD_ADD  = 3'd0,
        CMD_NAND = 3'd1,
        CMD_LW   = 3'd2,
        CMD_SW   = 3'd3,
        CMD_BEQ  = 3'd4,
        CMD_JALR = 3'd5,
        CMD_HALT = 3'd6,
        CMD_NOOP = 3'd7
    } cmd_t;

    typedef struct packed {
        logic [2:0]         command;
        logic [2:0]         reg_a;
        logic [2:0]         reg_b;
        logic [2:0]         dest_reg;
        logic signed [15:0] offset;
    } ercx_in_t;

    typedef struct packed {
        logic [15:0]        next_pc;
        logic               reg_written;
        logic [2:0]         written_index;
        logic signed [31:0] written_value;
        logic               branch_taken;
        logic [31:0]        executed_count;
    } ercx_out_t;

    // Register file write port
    typedef struct packed {
        logic              en;
        logic [REG_AW-1:0] idx;
        logic [DATA_W-1:0] val;
    } ercx_wb_t;

    // Execute stage decisions
    typedef struct packed {
        logic [PC_W-1:0]   npc;
        logic              wr;
        logic [REG_AW-1:0] widx;
        logic [DATA_W-1:0] wval;
        logic              taken;
        logic              is_lw;
        logic              is_sw;
        logic [MEM_AW-1:0] mem_addr;
    } ercx_exec_t;

endpackage

FILE: hdl/eight_register_cpu_execute.sv
`timescale 1ns / 1ps

// Executes one decoded instruction per accepted request on a machine with
// eight 32-bit registers, a 16-bit PC and a MEM_DEPTH-word data memory.
// Throughput is one instruction per cycle while results are taken; a request
// passes the execute register and then the result register. The register
// file is read at acceptance and the data memory in the execute stage, both
// registered. Register and load results are forwarded, so back-to-back
// dependent instructions need no bubbles. The whole pipe holds while a result
// waits to be taken. Registers reset to zero; the data memory is not cleared,
// so a load of a word never stored since reset returns an undefined value.
module eight_register_cpu_execute (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 req_valid,
    output logic                 req_ready,
    input  ercx_pkg::ercx_in_t   req_data,
    output logic                 res_valid,
    input  logic                 res_ready,
    output ercx_pkg::ercx_out_t  res_data
);

    import ercx_pkg::*;

    logic              adv;
    logic              ex_valid_reg;
    ercx_in_t          ex_reg;
    logic [PC_W-1:0]   pc_reg;
    logic [DATA_W-1:0] cnt_reg;
    logic              res_valid_reg;
    ercx_out_t         res_reg;
    logic              res_lw_reg;
    ercx_wb_t          wb_reg;
    ercx_wb_t          wb_now;
    logic [DATA_W-1:0] rf_a;
    logic [DATA_W-1:0] rf_b;
    logic [DATA_W-1:0] dmem_rdata;
    logic [DATA_W-1:0] res_val;
    logic [DATA_W-1:0] va;
    logic [DATA_W-1:0] vb;
    ercx_exec_t        ex;

    assign adv       = !res_valid_reg || res_ready;
    assign req_ready = adv;
    assign res_valid = res_valid_reg;

    // Load data comes straight from the memory read register
    assign res_val = res_lw_reg ? dmem_rdata : res_reg.written_value;

    always_comb
    begin
        res_data               = res_reg;
        res_data.written_value = res_val;
    end

    // Register write happens when the result is taken
    assign wb_now.en  = res_valid_reg && res_ready && res_reg.reg_written;
    assign wb_now.idx = res_reg.written_index;
    assign wb_now.val = res_val;

    ercx_regfile u_regfile (
        .clk       (clk),
        .rst_n     (rst_n),
        .rd_en     (adv),
        .rd_addr_a (req_data.reg_a),
        .rd_addr_b (req_data.reg_b),
        .wb        (wb_now),
        .rd_a      (rf_a),
        .rd_b      (rf_b)
    );

    // Forward from the pending result, then from the write that landed
    // on the same edge as the operand read
    always_comb
    begin
        if (res_valid_reg && res_reg.reg_written && res_reg.written_index == ex_reg.reg_a)
        begin
            va = res_val;
        end
        else if (wb_reg.en && wb_reg.idx == ex_reg.reg_a)
        begin
            va = wb_reg.val;
        end
        else
        begin
            va = rf_a;
        end

        if (res_valid_reg && res_reg.reg_written && res_reg.written_index == ex_reg.reg_b)
        begin
            vb = res_val;
        end
        else if (wb_reg.en && wb_reg.idx == ex_reg.reg_b)
        begin
            vb = wb_reg.val;
        end
        else
        begin
            vb = rf_b;
        end
    end

    ercx_alu u_alu (
        .ins (ex_reg),
        .va  (va),
        .vb  (vb),
        .pc  (pc_reg),
        .ex  (ex)
    );

    ercx_ram #(.WIDTH(DATA_W), .DEPTH(MEM_DEPTH)) u_dmem (
        .clk   (clk),
        .we    (adv && ex_valid_reg && ex.is_sw),
        .waddr (ex.mem_addr),
        .wdata (vb),
        .re    (adv),
        .raddr (ex.mem_addr),
        .rdata (dmem_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ex_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
            pc_reg        <= '0;
            cnt_reg       <= '0;
            wb_reg        <= '0;
        end
        else if (adv)
        begin
            ex_valid_reg  <= req_valid;
            res_valid_reg <= ex_valid_reg;
            wb_reg        <= wb_now;
            if (ex_valid_reg)
            begin
                pc_reg  <= ex.npc;
                cnt_reg <= cnt_reg + DATA_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ex_reg                 <= req_data;
            res_lw_reg             <= ex.is_lw;
            res_reg.next_pc        <= ex.npc;
            res_reg.reg_written    <= ex.wr;
            res_reg.written_index  <= ex.widx;
            res_reg.written_value  <= ex.wval;
            res_reg.branch_taken   <= ex.taken;
            res_reg.executed_count <= cnt_reg + DATA_W'(1);
        end
    end

endmodule

FILE: hdl/ercx_ram.sv
`timescale 1ns / 1ps

module ercx_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                                    clk,
    input  logic                                    we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                        wdata,
    input  logic                                    re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Read returns the old word on a same-address write
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: hdl/ercx_regfile.sv
`timescale 1ns / 1ps

module ercx_regfile (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             rd_en,
    input  logic [ercx_pkg::REG_AW-1:0]      rd_addr_a,
    input  logic [ercx_pkg::REG_AW-1:0]      rd_addr_b,
    input  ercx_pkg::ercx_wb_t               wb,
    output logic [ercx_pkg::DATA_W-1:0]      rd_a,
    output logic [ercx_pkg::DATA_W-1:0]      rd_b
);

    import ercx_pkg::*;

    logic [NUM_REGS-1:0] vld_reg;
    logic                rd_vld_a_reg;
    logic                rd_vld_b_reg;
    logic [DATA_W-1:0]   ram_a;
    logic [DATA_W-1:0]   ram_b;

    // Two copies so both operands read in the same cycle
    ercx_ram #(.WIDTH(DATA_W), .DEPTH(NUM_REGS)) u_ram_a (
        .clk   (clk),
        .we    (wb.en),
        .waddr (wb.idx),
        .wdata (wb.val),
        .re    (rd_en),
        .raddr (rd_addr_a),
        .rdata (ram_a)
    );

    ercx_ram #(.WIDTH(DATA_W), .DEPTH(NUM_REGS)) u_ram_b (
        .clk   (clk),
        .we    (wb.en),
        .waddr (wb.idx),
        .wdata (wb.val),
        .re    (rd_en),
        .raddr (rd_addr_b),
        .rdata (ram_b)
    );

    // Registers never written since reset read as zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg      <= '0;
            rd_vld_a_reg <= 1'b0;
            rd_vld_b_reg <= 1'b0;
        end
        else
        begin
            if (wb.en)
            begin
                vld_reg[wb.idx] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_vld_a_reg <= vld_reg[rd_addr_a];
                rd_vld_b_reg <= vld_reg[rd_addr_b];
            end
        end
    end

    assign rd_a = rd_vld_a_reg ? ram_a : '0;
    assign rd_b = rd_vld_b_reg ? ram_b : '0;

endmodule

FILE: hdl/ercx_alu.sv
`timescale 1ns / 1ps

module ercx_alu (
    input  ercx_pkg::ercx_in_t              ins,
    input  logic [ercx_pkg::DATA_W-1:0]     va,
    input  logic [ercx_pkg::DATA_W-1:0]     vb,
    input  logic [ercx_pkg::PC_W-1:0]       pc,
    output ercx_pkg::ercx_exec_t            ex
);

    import ercx_pkg::*;

    logic [PC_W-1:0]   pc1;
    logic [DATA_W-1:0] off_ext;
    logic [DATA_W-1:0] addr_sum;
    logic              eq;

    assign pc1      = pc + PC_W'(1);
    assign off_ext  = {{(DATA_W-16){ins.offset[15]}}, ins.offset};
    assign addr_sum = va + off_ext;
    assign eq       = (va == vb);

    always_comb
    begin
        ex          = '0;
        ex.npc      = pc1;
        ex.mem_addr = addr_sum[MEM_AW-1:0];
        case (ins.command)
            CMD_ADD:
            begin
                ex.wr   = 1'b1;
                ex.widx = ins.dest_reg;
                ex.wval = va + vb;
            end
            CMD_NAND:
            begin
                ex.wr   = 1'b1;
                ex.widx = ins.dest_reg;
                ex.wval = ~(va & vb);
            end
            CMD_LW:
            begin
                // value arrives from data memory one stage later
                ex.wr    = 1'b1;
                ex.widx  = ins.reg_b;
                ex.is_lw = 1'b1;
            end
            CMD_SW:
            begin
                ex.is_sw = 1'b1;
            end
            CMD_BEQ:
            begin
                if (eq)
                begin
                    ex.taken = 1'b1;
                    ex.npc   = pc1 + ins.offset[PC_W-1:0];
                end
            end
            CMD_JALR:
            begin
                ex.wr   = 1'b1;
                ex.widx = ins.reg_b;
                ex.wval = DATA_W'(pc1);
                ex.npc  = eq ? pc1 : va[PC_W-1:0];
            end
            default:
            begin
                ex.npc = pc1;
            end
        endcase
    end

endmodule

FILE: hdl/ercx_checker.sv
`timescale 1ns / 1ps

module ercx_checker (
    input logic                 clk,
    input logic                 rst_n,
    input logic                 req_valid,
    input logic                 req_ready,
    input ercx_pkg::ercx_in_t   req_data,
    input logic                 res_valid,
    input logic                 res_ready,
    input ercx_pkg::ercx_out_t  res_data
);

    // A stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res_data))
        else $error("result changed while stalled");

    // Every accepted request is followed by a valid result
    assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |-> ##2 res_valid)
        else $error("result missing after request");

    // No register write means zero index and value
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_data.reg_written |->
            res_data.written_index == 3'd0 && res_data.written_value == 32'sd0)
        else $error("write fields set without a write");

    // A taken branch never writes a register
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_data.branch_taken |-> !res_data.reg_written)
        else $error("taken branch wrote a register");

    // Consecutive results count up by one
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_ready ##1 res_valid |->
            res_data.executed_count == $past(res_data.executed_count) + 32'd1)
        else $error("executed count skipped");

endmodule

bind eight_register_cpu_execute ercx_checker u_ercx_checker (.*);
